### src/srrb_pkg.sv
`default_nettype none

package srrb_pkg;

   // request selector carried in tuser
   typedef enum logic [1:0] {
      FUNC_RECEIVE = 2'd0,
      FUNC_TAKE    = 2'd1,
      FUNC_FLUSH   = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_FRAME   = 3'd1;
   localparam logic [2:0] ERR_OVERRUN = 3'd2;
   localparam logic [2:0] ERR_PARITY  = 3'd3;
   localparam logic [2:0] ERR_FULL    = 3'd4;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   // controller to datapath
   typedef struct packed {
      logic store;       // receive beat: check flags, write ring
      logic pop;         // issue ring read, advance read pointer
      logic report;      // empty take: return latched error and clear it
      logic flush;       // pointers back to zero
      logic load_blank;  // result of zeros
      logic load_pop;    // result from ring read data
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic slot_free;
   } sts_type;

endpackage

`default_nettype wire

### src/srrb_ram.sv
`default_nettype none

module srrb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### src/srrb_ctrl.sv
`default_nettype none

module srrb_ctrl
   import srrb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [1:0] req_tuser,
   input  wire sts_type    sts,
   output cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   func_type  func;

   assign func = func_type'(req_tuser);

   always_comb begin
      req_tready = (state_ff == ST_IDLE) && sts.slot_free;
      accept     = req_tvalid && req_tready;
      cmd        = '0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func)
                  FUNC_RECEIVE: begin
                     cmd.store      = 1'b1;
                     cmd.load_blank = 1'b1;
                  end
                  FUNC_TAKE: begin
                     if (sts.empty) begin
                        cmd.report = 1'b1;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  FUNC_FLUSH: begin
                     cmd.flush      = 1'b1;
                     cmd.load_blank = 1'b1;
                  end
                  default: begin
                     cmd.load_blank = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // ring data is out of the ram now; result slot was freed at accept
            cmd.load_pop = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/srrb_dp.sv
`default_nettype none

module srrb_dp
   import srrb_pkg::*;
#(
   parameter int unsigned RING_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_data,
   input  wire cmd_type               cmd,
   output sts_type                    sts
);

   localparam int unsigned AW = $clog2(RING_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0]    pend_ff, pend_in;
   logic          thru_ff, thru_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          echo_ff, echo_in;
   logic [2:0]    err_ff, err_in;

   logic [7:0]    rx_byte;
   logic          frame_error;
   logic          overrun_error;
   logic          parity_error;
   logic [AW-1:0] wr_next;
   logic [AW-1:0] rd_next;
   logic          ram_wr;
   logic [7:0]    ram_rdata;
   logic          load;

   assign rx_byte       = req_tdata[7:0];
   assign frame_error   = req_tdata[8];
   assign overrun_error = req_tdata[9];
   assign parity_error  = req_tdata[10];

   assign wr_next = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_next = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
   assign ram_wr  = cmd.store && !frame_error && !overrun_error && !parity_error;

   srrb_ram #(
      .WIDTH(8),
      .DEPTH(RING_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(wr_ptr_ff),
      .wr_data(rx_byte),
      .rd_en  (cmd.pop),
      .rd_addr(rd_ptr_ff),
      .rd_data(ram_rdata)
   );

   assign sts.empty     = (rd_ptr_ff == wr_ptr_ff);
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready     = 1'b1;
   assign load          = cmd.load_blank || cmd.load_pop || cmd.report;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      pend_in   = pend_ff;
      thru_in   = (csr_valid && csr_ready) ? csr_data : thru_ff;

      if (cmd.store) begin
         if (frame_error) begin
            pend_in = ERR_FRAME;
         end else if (overrun_error) begin
            pend_in = ERR_OVERRUN;
         end else if (parity_error) begin
            pend_in = ERR_PARITY;
         end else begin
            wr_ptr_in = wr_next;
            // writer caught the reader: ring wraps to empty
            if (wr_next == rd_ptr_ff) begin
               pend_in = ERR_FULL;
            end
         end
      end
      if (cmd.pop) begin
         rd_ptr_in = rd_next;
      end
      if (cmd.report) begin
         pend_in = ERR_NONE;
      end
      if (cmd.flush) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
      end

      out_valid_in = cmd.load_pop;
      out_byte_in  = cmd.load_pop ? ram_rdata : 8'd0;
      echo_in      = cmd.load_pop && thru_ff;
      err_in       = cmd.report ? pend_ff : ERR_NONE;

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         pend_ff      <= ERR_NONE;
         thru_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         pend_ff      <= pend_in;
         thru_ff      <= thru_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_valid_ff <= out_valid_in;
         out_byte_ff  <= out_byte_in;
         echo_ff      <= echo_in;
         err_ff       <= err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, err_ff, echo_ff, out_byte_ff, out_valid_ff};

endmodule

`default_nettype wire

### src/serial_receive_ring_buffer_unit.sv
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+----------------------------------------------
// req       | req_tvalid/req_tready  | tuser func, tdata rx_byte + error flags
// rsp       | rsp_tvalid/rsp_tready  | tdata out_valid, out_byte, echo_valid, error
// csr       | csr_valid/csr_ready    | csr_data = thru_enable
//
// receive, flush, empty take and unused beats load the result register directly; a take
// that pops a byte first passes through ST_READ for the registered read of the ring ram.
// one result register sits on the rsp side; a new beat is taken while the held
// result leaves in the same cycle, and req stalls while rsp is backed up.
// reset (synchronous) clears the pointers, the latched error and thru_enable;
// ring contents are not cleared and need no clearing pass.

module serial_receive_ring_buffer_unit
   import srrb_pkg::*;
#(
   parameter int unsigned RING_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] rx_byte, [8] frame_error, [9] overrun_error, [10] parity_error
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] out_valid, [8:1] out_byte, [9] echo_valid, [12:10] error_code
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_data
);

   cmd_type cmd;
   sts_type sts;

   srrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .sts       (sts),
      .cmd       (cmd)
   );

   srrb_dp #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

### verif/serial_receive_ring_buffer_unit_tb.sv
`default_nettype none

module serial_receive_ring_buffer_unit_tb;
   import srrb_pkg::*;

   localparam int unsigned RING_DEPTH = 32;

   class ring_buffer_scoreboard;
      logic [7:0]            ring_copy [RING_DEPTH];
      int unsigned           rd_ptr;
      int unsigned           wr_ptr;
      logic [2:0]            latched_err;
      logic                  thru;
      logic [RSP_DATA_W-1:0] pending_rsp [$];
      int unsigned           fail_count;

      function new();
         rd_ptr      = 0;
         wr_ptr      = 0;
         latched_err = ERR_NONE;
         thru        = 1'b0;
         fail_count  = 0;
      endfunction

      // works out the result of one accepted request beat
      function void note_request(func_type func, logic [7:0] rx, logic fe, logic ov,
                                 logic pe);
         logic       vld;
         logic       echo;
         logic [7:0] data;
         logic [2:0] err;
         vld  = 1'b0;
         echo = 1'b0;
         data = 8'h00;
         err  = ERR_NONE;
         case (func)
            FUNC_RECEIVE: begin
               if (fe) latched_err = ERR_FRAME;
               else if (ov) latched_err = ERR_OVERRUN;
               else if (pe) latched_err = ERR_PARITY;
               else begin
                  ring_copy[wr_ptr] = rx;
                  wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                  // writer caught the reader: contents lost, ring reads empty
                  if (wr_ptr == rd_ptr) latched_err = ERR_FULL;
               end
            end
            FUNC_TAKE: begin
               if (rd_ptr != wr_ptr) begin
                  vld    = 1'b1;
                  data   = ring_copy[rd_ptr];
                  echo   = thru;
                  rd_ptr = (rd_ptr + 1) % RING_DEPTH;
               end else begin
                  err         = latched_err;
                  latched_err = ERR_NONE;
               end
            end
            FUNC_FLUSH: begin
               rd_ptr = 0;
               wr_ptr = 0;
            end
            default: ;
         endcase
         pending_rsp.push_back({3'b000, err, echo, data, vld});
      endfunction

      function void report_mismatch(string field, int unsigned want, int unsigned got);
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] got);
         logic [RSP_DATA_W-1:0] want;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result beat", 0, 32'(got));
            return;
         end
         want = pending_rsp.pop_front();
         if (got[0] !== want[0]) report_mismatch("out_valid", 32'(want[0]), 32'(got[0]));
         if (got[8:1] !== want[8:1])
            report_mismatch("out_byte", 32'(want[8:1]), 32'(got[8:1]));
         if (got[9] !== want[9]) report_mismatch("echo_valid", 32'(want[9]), 32'(got[9]));
         if (got[12:10] !== want[12:10])
            report_mismatch("error_code", 32'(want[12:10]), 32'(got[12:10]));
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic                  csr_data   = 1'b0;

   ring_buffer_scoreboard sb;
   bit                    steady_flow  = 1'b0;
   bit                    hold_request = 1'b0;

   serial_receive_ring_buffer_unit #(
      .RING_DEPTH(RING_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   task automatic send_item(func_type func, logic [7:0] rx, logic fe, logic ov, logic pe);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {5'b00000, pe, ov, fe, rx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, rx, fe, ov, pe);
   endtask

   task automatic send_clean(func_type func, logic [7:0] rx);
      send_item(func, rx, 1'b0, 1'b0, 1'b0);
   endtask

   // block is idle only once every result beat has left
   task automatic write_thru(logic value);
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.thru = value;
   endtask

   task automatic run_random_phase(int unsigned count, int unsigned hold_at);
      int unsigned sent;
      int unsigned kind;
      int unsigned len;
      logic [2:0]  flags;
      bit          held;
      sent = 0;
      held = 1'b0;
      while (sent < count) begin
         if (!held && sent >= hold_at) begin
            hold_request = 1'b1;
            held         = 1'b1;
         end
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               // fill burst, often exactly one ring's worth so the writer wraps
               case ($urandom_range(0, 3))
                  0: len = RING_DEPTH;
                  1: len = RING_DEPTH - 1;
                  2: len = RING_DEPTH + 1;
                  default: len = $urandom_range(1, 40);
               endcase
               repeat (len) send_clean(FUNC_RECEIVE, 8'($urandom_range(0, 255)));
               sent += len;
            end
            3, 4: begin
               len = $urandom_range(1, 40);
               repeat (len) send_clean(FUNC_TAKE, 8'($urandom_range(0, 255)));
               sent += len;
            end
            5: begin
               flags = 3'($urandom_range(1, 7));
               send_item(FUNC_RECEIVE, 8'($urandom_range(0, 255)), flags[0], flags[1],
                         flags[2]);
               send_clean(FUNC_TAKE, 8'h00);
               sent += 2;
            end
            6: begin
               send_clean(FUNC_FLUSH, 8'($urandom_range(0, 255)));
               sent += 1;
            end
            7: begin
               len = $urandom_range(1, 30);
               repeat (len)
                  send_clean($urandom_range(0, 1) ? FUNC_TAKE : FUNC_RECEIVE,
                             8'($urandom_range(0, 255)));
               sent += len;
            end
            default: begin
               len = $urandom_range(1, 8);
               repeat (len)
                  send_item(func_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
               sent += len;
            end
         endcase
      end
   endtask

   initial begin : result_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            // long hold-off so the request side backs up
            stall        = 150;
            hold_request = 1'b0;
         end else begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   initial begin : stimulus
      logic thru_plan [6];
      sb = new();
      thru_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_thru(1'b0);

      send_clean(FUNC_TAKE, 8'h00);                  // empty take, nothing latched
      send_clean(FUNC_UNUSED, 8'hFF);
      send_clean(FUNC_RECEIVE, 8'h00);
      send_clean(FUNC_RECEIVE, 8'hFF);
      send_clean(FUNC_TAKE, 8'h00);
      send_clean(FUNC_TAKE, 8'h00);
      send_item(FUNC_RECEIVE, 8'hA5, 1'b1, 1'b0, 1'b0);
      send_clean(FUNC_TAKE, 8'h00);
      send_item(FUNC_RECEIVE, 8'h5A, 1'b0, 1'b1, 1'b0);
      send_clean(FUNC_TAKE, 8'h00);
      send_item(FUNC_RECEIVE, 8'h0F, 1'b0, 1'b0, 1'b1);
      send_clean(FUNC_TAKE, 8'h00);
      // several flags at once: highest priority wins
      send_item(FUNC_RECEIVE, 8'hF0, 1'b1, 1'b1, 1'b1);
      send_clean(FUNC_TAKE, 8'h00);
      send_item(FUNC_RECEIVE, 8'h33, 1'b0, 1'b1, 1'b1);
      send_clean(FUNC_TAKE, 8'h00);
      // last error overwrites the latched one
      send_item(FUNC_RECEIVE, 8'h11, 1'b1, 1'b0, 1'b0);
      send_item(FUNC_RECEIVE, 8'h22, 1'b0, 1'b0, 1'b1);
      send_clean(FUNC_TAKE, 8'h00);
      // take with data leaves the latched error alone
      send_item(FUNC_RECEIVE, 8'h44, 1'b0, 1'b1, 1'b0);
      send_clean(FUNC_RECEIVE, 8'h5A);
      send_clean(FUNC_TAKE, 8'h00);
      // flush keeps the latched error
      send_clean(FUNC_RECEIVE, 8'h3C);
      send_clean(FUNC_FLUSH, 8'h00);
      send_clean(FUNC_TAKE, 8'h00);
      send_clean(FUNC_TAKE, 8'h00);

      for (int phase = 0; phase < 6; phase++) begin
         write_thru(thru_plan[phase]);
         steady_flow = (phase == 3);
         run_random_phase(320, (phase == 2) ? 50 : 1000);
      end

      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("serial_receive_ring_buffer_unit_tb passed");
      end else begin
         $display("serial_receive_ring_buffer_unit_tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(12 * 500000);
      $display("serial_receive_ring_buffer_unit_tb failed");
      $finish;
   end

endmodule

`default_nettype wire
